/* rtl/core/fpsc_pkg.sv */
// ----------------------------------------------------------------------------
// fpsc_pkg
// Shared types and constants for the fan PWM speed control block.
// ----------------------------------------------------------------------------
package fpsc_pkg;

    localparam int unsigned P_PERIOD_TICKS = 100;

    localparam int unsigned DUTY_W  = 7;
    localparam int unsigned SPEED_W = 8;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned MAG_W   = 14;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd100;

    // floor(m / 100) == (m * RECIP_100) >> RECIP_SHIFT for m <= 9900
    localparam int unsigned          RECIP_W     = 13;
    localparam logic [RECIP_W-1:0]   RECIP_100   = 13'd5243;
    localparam int unsigned          RECIP_SHIFT = 19;

    localparam logic [DUTY_W-1:0] MIN_DUTY_RST = 7'd32;
    localparam logic [DUTY_W-1:0] MAX_DUTY_RST = 7'd99;
    localparam logic [DUTY_W-1:0] DUTY_RST     = 7'd32;
    localparam logic [DUTY_W-1:0] DUTY_ZERO    = 7'd1;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    localparam logic REG_MIN_DUTY = 1'b0;
    localparam logic REG_MAX_DUTY = 1'b1;

    typedef struct packed {
        logic              action;
        logic              zero;
        logic              neg;
        logic [MAG_W-1:0]  mag;
    } t_item;

    typedef struct packed {
        logic [DUTY_W-1:0] min_duty;
        logic [DUTY_W-1:0] max_duty;
    } t_cfg;

endpackage

/* rtl/core/fan_pwm_speed_control_top.sv */
// ----------------------------------------------------------------------------
// fan_pwm_speed_control_top
// Fan speed PWM generator: speed settings and ticks in, level and duty out.
//
//   Channel   Direction  Handshake                 Payload
//   in        in         i_in_valid / o_in_stall   i_action, i_speed_percent
//   out       out        o_out_valid / i_out_stall o_pwm_level, o_duty_now
//   cfg       in         APB psel/penable/pready   min_duty @0x0, max_duty @0x4
//
// One transfer per cycle while the output is not stalled; each input transfer
// passes through the input register, then the result register.
// Reset (synchronous, i_rst_n low) clears both stages and loads the PWM state.
// A stall on the output holds the result; the input stalls only while its
// register is full and cannot move into the result register.
// ----------------------------------------------------------------------------
module fan_pwm_speed_control_top
    import fpsc_pkg::*;
#(
    parameter int unsigned PERIOD_TICKS = P_PERIOD_TICKS
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic [SPEED_W-1:0] i_speed_percent,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_pwm_level,
    output logic [DUTY_W-1:0]  o_duty_now,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    t_cfg  cfg;
    t_item item;
    logic  item_valid;
    logic  advance;

    assign advance = item_valid & (~o_out_valid | ~i_out_stall);

    fpsc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fpsc_in_stage u_in_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_speed_percent (i_speed_percent),
        .i_cfg           (cfg),
        .i_advance       (advance),
        .o_valid         (item_valid),
        .o_item          (item)
    );

    fpsc_pwm #(
        .PERIOD_TICKS (PERIOD_TICKS)
    ) u_pwm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_item      (item),
        .i_cfg       (cfg),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_pwm_level (o_pwm_level),
        .o_duty_now  (o_duty_now)
    );

endmodule

/* rtl/core/fpsc_cfg.sv */
// ----------------------------------------------------------------------------
// fpsc_cfg
// APB register file holding the minimum and maximum duty settings.
// ----------------------------------------------------------------------------
module fpsc_cfg
    import fpsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [DUTY_W-1:0] r_min_duty;
    logic [DUTY_W-1:0] r_max_duty;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_duty <= MIN_DUTY_RST;
            r_max_duty <= MAX_DUTY_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_MIN_DUTY: r_min_duty <= pwdata[DUTY_W-1:0];
                REG_MAX_DUTY: r_max_duty <= pwdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_MIN_DUTY: prdata[DUTY_W-1:0] = r_min_duty;
            REG_MAX_DUTY: prdata[DUTY_W-1:0] = r_max_duty;
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.min_duty = r_min_duty;
    assign o_cfg.max_duty = r_max_duty;

endmodule

/* rtl/core/fpsc_in_stage.sv */
// ----------------------------------------------------------------------------
// fpsc_in_stage
// Input register: clamps the speed byte and registers setting * |span|.
// ----------------------------------------------------------------------------
module fpsc_in_stage
    import fpsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic [SPEED_W-1:0] i_speed_percent,
    input  t_cfg               i_cfg,
    input  logic               i_advance,
    output logic               o_valid,
    output t_item              o_item
);

    logic              r_valid;
    logic              n_valid;
    t_item             r_item;
    t_item             n_item;
    logic              accept;
    logic [DUTY_W-1:0] clamped;
    logic [DUTY_W-1:0] abs_span;

    assign o_in_stall = r_valid & ~i_advance;
    assign accept     = i_in_valid & ~o_in_stall;

    always_comb begin
        clamped       = (i_speed_percent > SPEED_MAX) ? SPEED_MAX[DUTY_W-1:0]
                                                      : i_speed_percent[DUTY_W-1:0];
        n_item.action = i_action;
        n_item.zero   = (i_speed_percent == '0);
        n_item.neg    = (i_cfg.max_duty < i_cfg.min_duty);
        abs_span      = n_item.neg ? (i_cfg.min_duty - i_cfg.max_duty)
                                   : (i_cfg.max_duty - i_cfg.min_duty);
        n_item.mag    = MAG_W'(clamped) * MAG_W'(abs_span);
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/core/fpsc_pwm.sv */
// ----------------------------------------------------------------------------
// fpsc_pwm
// Duty mapping, PWM phase state and result register.
// ----------------------------------------------------------------------------
module fpsc_pwm
    import fpsc_pkg::*;
#(
    parameter int unsigned PERIOD_TICKS = P_PERIOD_TICKS
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  t_item             i_item,
    input  t_cfg              i_cfg,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_pwm_level,
    output logic [DUTY_W-1:0] o_duty_now
);

    localparam logic [CNT_W-1:0] PERIOD = CNT_W'(PERIOD_TICKS);
    localparam int unsigned      PROD_W = MAG_W + RECIP_W;

    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_level;
    logic [DUTY_W-1:0] r_duty;
    logic [DUTY_W-1:0] n_duty;
    logic              r_phase_high;
    logic              n_phase_high;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  n_len;
    logic [PROD_W-1:0] prod;
    logic [DUTY_W-1:0] quot;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  low_len;
    logic [CNT_W-1:0]  duty_ext;

    always_comb begin
        prod     = PROD_W'(i_item.mag) * PROD_W'(RECIP_100);
        quot     = prod[RECIP_SHIFT +: DUTY_W];
        duty_ext = CNT_W'(r_duty);
        low_len  = (duty_ext >= PERIOD) ? '0 : (PERIOD - duty_ext);
        cnt_inc  = r_count + 1'b1;

        n_duty       = r_duty;
        n_phase_high = r_phase_high;
        n_count      = r_count;
        n_len        = r_len;

        case (i_item.action)
            ACT_SET: begin
                if (i_item.zero) begin
                    n_duty = DUTY_ZERO;
                end else if (i_item.neg) begin
                    n_duty = i_cfg.min_duty - quot;
                end else begin
                    n_duty = i_cfg.min_duty + quot;
                end
            end
            ACT_TICK: begin
                n_count = cnt_inc;
                if (cnt_inc >= r_len) begin
                    n_count = '0;
                    if (r_phase_high) begin
                        if (low_len == '0) begin
                            n_len = duty_ext;
                        end else begin
                            n_phase_high = 1'b0;
                            n_len        = low_len;
                        end
                    end else begin
                        if (r_duty == '0) begin
                            n_len = low_len;
                        end else begin
                            n_phase_high = 1'b1;
                            n_len        = duty_ext;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_duty       <= DUTY_RST;
            r_phase_high <= 1'b1;
            r_count      <= '0;
            r_len        <= CNT_W'(DUTY_RST);
        end else begin
            r_out_valid <= n_out_valid;
            if (i_advance) begin
                r_duty       <= n_duty;
                r_phase_high <= n_phase_high;
                r_count      <= n_count;
                r_len        <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_level <= r_phase_high;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pwm_level = r_level;
    assign o_duty_now  = r_duty;

    a_count_in_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < r_len)
        else $error("phase count reached phase length");

    a_set_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_item.action == ACT_SET) |=>
            ($stable(r_phase_high) && $stable(r_count) && $stable(r_len)))
        else $error("speed setting moved the PWM phase");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> ($stable(r_duty) && $stable(r_count) && $stable(r_phase_high)))
        else $error("state changed without a transfer");

endmodule
